FILE: hw/rtl/fnsa_pkg.sv
package fnsa_pkg;

    // Field widths of the sample and point transactions
    localparam int SAMPLE_FIELD_W = 8;
    localparam int ROW_W          = 6;
    localparam int COL_W          = 6;
    localparam int AVG_W          = 10;

    // Configuration port
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INTERIOR_ROWS = 1'b0,
        REG_INTERIOR_COLS = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] INTERIOR_RESET = 6'd62;

    // Row counter parks here, one row below the largest window row (63)
    localparam int ROW_CNT_W = 7;
    localparam logic [ROW_CNT_W-1:0] ROW_CAP = 7'd64;

    // Largest neighbor sum for an 8-bit sample
    localparam logic [AVG_W-1:0] AVG_MAX = 10'd1020;

    typedef struct packed {
        logic [ROW_W-1:0] point_row;
        logic [COL_W-1:0] point_col;
        logic [AVG_W-1:0] average_quarters;
        logic             last_point;
    } point_t;

endpackage

FILE: hw/rtl/fnsa_channels.sv
interface fnsa_in_if;
    logic                                valid;
    logic                                ready;
    logic [fnsa_pkg::SAMPLE_FIELD_W-1:0] grid_sample;
    logic                                frame_start;

    modport source (output valid, output grid_sample, output frame_start, input ready);
    modport sink (input valid, input grid_sample, input frame_start, output ready);
endinterface

interface fnsa_out_if;
    logic                       valid;
    logic                       ready;
    logic [fnsa_pkg::ROW_W-1:0] point_row;
    logic [fnsa_pkg::COL_W-1:0] point_col;
    logic [fnsa_pkg::AVG_W-1:0] average_quarters;
    logic                       last_point;

    modport source (output valid, output point_row, output point_col,
                    output average_quarters, output last_point, input ready);
    modport sink (input valid, input point_row, input point_col,
                  input average_quarters, input last_point, output ready);
endinterface

FILE: hw/rtl/fnsa_cell.sv
module fnsa_cell #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         shift_en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

FILE: hw/rtl/fnsa_chain.sv
module fnsa_chain #(
    parameter int DEPTH = 128,
    parameter int W     = 8
) (
    input  logic                    clk,
    input  logic                    shift_en,
    input  logic [W-1:0]            d,
    output logic [DEPTH-1:0][W-1:0] taps
);

    // Cell k holds the sample taken k+1 transactions ago
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            fnsa_cell #(.W(W)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (d),
                .q        (taps[k])
            );
        end
        else
        begin : g_body
            fnsa_cell #(.W(W)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (taps[k-1]),
                .q        (taps[k])
            );
        end
    end

endmodule

FILE: hw/rtl/fnsa_out_buf.sv
module fnsa_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fnsa_pkg::point_t  push_item,
    output logic              can_push,
    fnsa_out_if.source        out
);

    fnsa_pkg::point_t main_reg;
    fnsa_pkg::point_t skid_reg;
    logic             main_valid_reg;
    logic             skid_valid_reg;
    logic             pop;
    logic             load_main;

    assign pop       = main_valid_reg && out.ready;
    assign load_main = !main_valid_reg || pop;
    assign can_push  = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (load_main)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (load_main)
        begin
            if (push)
            begin
                main_reg <= push_item;
            end
        end
        else if (push)
        begin
            skid_reg <= push_item;
        end
    end

    assign out.valid            = main_valid_reg;
    assign out.point_row        = main_reg.point_row;
    assign out.point_col        = main_reg.point_col;
    assign out.average_quarters = main_reg.average_quarters;
    assign out.last_point       = main_reg.last_point;

endmodule

FILE: hw/rtl/four_neighbor_stencil_average_unit.sv
// Output: a point is formed as the sample one row below it is taken, then registered.
// Throughput: one sample per cycle; the sample port stays ready while a single
//   finished point waits downstream and drops only when a second one is held.
// Reset: rst_n is asynchronous, active low; clears positions, output valids and
//   sets both window registers to 62. The delay line is not cleared.
module four_neighbor_stencil_average_unit #(
    parameter int GRID_WIDTH  = 64,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fnsa_in_if.sink                             samples,
    fnsa_out_if.source                          points,
    input  logic                                cfg_we,
    input  logic [fnsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fnsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Stored sample width: the field carries at most 8 bits
    localparam int SW = (SAMPLE_BITS < fnsa_pkg::SAMPLE_FIELD_W) ?
                        SAMPLE_BITS : fnsa_pkg::SAMPLE_FIELD_W;
    localparam int CW = $clog2(GRID_WIDTH);
    // Compare width for columns against the 6-bit window register
    localparam int LW = (CW > fnsa_pkg::COL_W) ? CW : fnsa_pkg::COL_W;
    localparam int DEPTH   = 2 * GRID_WIDTH;
    localparam int COL_CAP = GRID_WIDTH - 2;

    // ---------------------------------------------------------------
    // Window registers
    // ---------------------------------------------------------------
    logic [fnsa_pkg::CFG_DATA_W-1:0] interior_rows_reg;
    logic [fnsa_pkg::CFG_DATA_W-1:0] interior_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interior_rows_reg <= fnsa_pkg::INTERIOR_RESET;
            interior_cols_reg <= fnsa_pkg::INTERIOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (fnsa_pkg::cfg_reg_t'(cfg_index))
                fnsa_pkg::REG_INTERIOR_ROWS: interior_rows_reg <= cfg_data;
                fnsa_pkg::REG_INTERIOR_COLS: interior_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Raster position of the incoming sample
    // ---------------------------------------------------------------
    logic [fnsa_pkg::ROW_CNT_W-1:0] row_reg, row_next;
    logic [CW-1:0]                  col_reg, col_next;
    logic [fnsa_pkg::ROW_CNT_W-1:0] r_cur;
    logic [CW-1:0]                  c_cur;
    logic                           accept;
    logic                           can_push;

    assign samples.ready = can_push;
    assign accept        = samples.valid && can_push;

    // frame_start puts this very sample at the origin
    assign r_cur = samples.frame_start ? '0 : row_reg;
    assign c_cur = samples.frame_start ? '0 : col_reg;

    always_comb
    begin
        row_next = r_cur;
        col_next = c_cur + CW'(1);
        if (c_cur == CW'(GRID_WIDTH - 1))
        begin
            col_next = '0;
            if (r_cur < fnsa_pkg::ROW_CAP)
            begin
                row_next = r_cur + fnsa_pkg::ROW_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------------------------------------------------------
    // Two-row delay line. Within one frame, relative to the sample at
    // (r, c): right neighbor (r-1, c+1) is GRID_WIDTH-1 transactions back,
    // left (r-1, c-1) is GRID_WIDTH+1 back, up (r-2, c) is 2*GRID_WIDTH back.
    // ---------------------------------------------------------------
    logic [SW-1:0]            down_s;
    logic [DEPTH-1:0][SW-1:0] taps;

    assign down_s = samples.grid_sample[SW-1:0];

    fnsa_chain #(.DEPTH(DEPTH), .W(SW)) u_chain (
        .clk      (clk),
        .shift_en (accept),
        .d        (down_s),
        .taps     (taps)
    );

    logic [SW-1:0] right_s, left_s, up_s;

    assign right_s = taps[GRID_WIDTH-2];
    assign left_s  = taps[GRID_WIDTH];
    assign up_s    = taps[DEPTH-1];

    // ---------------------------------------------------------------
    // Window test and neighbor sum for point (r-1, c)
    // ---------------------------------------------------------------
    logic [LW-1:0]                  c_ext, col_limit;
    logic [fnsa_pkg::ROW_CNT_W-1:0] r_pt;
    logic [fnsa_pkg::ROW_CNT_W-1:0] rows_ext;
    logic                           emit;
    logic                           last;
    logic [SW+1:0]                  sum;
    fnsa_pkg::point_t               item;

    assign c_ext    = LW'(c_cur);
    assign r_pt     = r_cur - fnsa_pkg::ROW_CNT_W'(1);
    assign rows_ext = fnsa_pkg::ROW_CNT_W'(interior_rows_reg);

    // Narrow grids clip the column window so a right neighbor exists
    always_comb
    begin
        col_limit = LW'(interior_cols_reg);
        if (col_limit > LW'(COL_CAP))
        begin
            col_limit = LW'(COL_CAP);
        end
    end

    assign emit = (r_cur >= fnsa_pkg::ROW_CNT_W'(2)) && (r_pt <= rows_ext) &&
                  (c_ext != '0) && (c_ext <= col_limit);
    assign last = (r_pt == rows_ext) && (c_ext == col_limit);

    assign sum = (SW+2)'(up_s) + (SW+2)'(left_s) + (SW+2)'(right_s) + (SW+2)'(down_s);

    always_comb
    begin
        item.point_row        = r_pt[fnsa_pkg::ROW_W-1:0];
        item.point_col        = c_ext[fnsa_pkg::COL_W-1:0];
        item.average_quarters = fnsa_pkg::AVG_W'(sum);
        item.last_point       = last;
    end

    // Output register plus skid stage
    fnsa_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_item (item),
        .can_push  (can_push),
        .out       (points)
    );

endmodule

FILE: hw/rtl/fnsa_checker.sv
module fnsa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [fnsa_pkg::ROW_W-1:0] point_row,
    input logic [fnsa_pkg::COL_W-1:0] point_col,
    input logic [fnsa_pkg::AVG_W-1:0] average_quarters,
    input logic                       last_point
);

    // A stalled point holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_row) &&
        $stable(point_col) && $stable(average_quarters) && $stable(last_point))
        else $error("stalled point transaction changed");

    // Only interior points leave the block
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_row != '0 && point_col != '0)
        else $error("boundary point emitted");

    // Sample port backs off only while a point is held at the output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("sample port stalled with empty output");

    // Four neighbors of at most 8 bits cannot exceed the bound
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> average_quarters <= fnsa_pkg::AVG_MAX)
        else $error("neighbor sum out of range");

endmodule

bind four_neighbor_stencil_average_unit fnsa_checker u_fnsa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (samples.ready),
    .out_valid        (points.valid),
    .out_ready        (points.ready),
    .point_row        (points.point_row),
    .point_col        (points.point_col),
    .average_quarters (points.average_quarters),
    .last_point       (points.last_point)
);
